// ===== rtl/core/bc_pkg.sv =====
// shared constants and controller/datapath interface types for the binomial coefficient unit
package bc_pkg;

  localparam int RESULT_BITS = 64;
  localparam int ARG_BITS    = 8;
  localparam int MAG_BITS    = ARG_BITS - 1;
  localparam int ROUND_BITS  = MAG_BITS - 1;
  localparam int PROD_BITS   = RESULT_BITS + MAG_BITS;
  localparam int BITCNT_BITS = $clog2(RESULT_BITS);
  localparam int IN_BITS     = 2 * ARG_BITS;
  localparam int COEF_BITS   = 64;
  localparam int OUT_BITS    = ((COEF_BITS + 1 + 7) / 8) * 8;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
  } bc_cmd_t;

  typedef struct packed {
    logic rounds_done;
    logic div_last;
  } bc_status_t;

endpackage

// ===== rtl/core/bc_ctrl.sv =====
// controller state machine sequencing multiply and divide rounds
module bc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  bc_pkg::bc_status_t status,
  output bc_pkg::bc_cmd_t   cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.mul      = 1'b0;
    cmd.div_step = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = status.rounds_done ? ST_OUT : ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_CHECK;
        end
      end
      ST_OUT: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);

endmodule

// ===== rtl/core/bc_datapath.sv =====
// accumulator, multiplier and bit-serial restoring divider
module bc_datapath (
  input  logic                              clk,
  input  logic signed [bc_pkg::ARG_BITS-1:0] n_value,
  input  logic signed [bc_pkg::ARG_BITS-1:0] k_value,
  input  bc_pkg::bc_cmd_t                   cmd,
  output bc_pkg::bc_status_t                status,
  output logic [bc_pkg::RESULT_BITS-1:0]    acc,
  output logic                              overflow
);

  logic [bc_pkg::MAG_BITS-1:0]    n_reg;
  logic [bc_pkg::ROUND_BITS-1:0]  rounds;
  logic [bc_pkg::ROUND_BITS-1:0]  idx;
  logic [bc_pkg::ROUND_BITS-1:0]  rem;
  logic [bc_pkg::BITCNT_BITS-1:0] bitcnt;

  logic                           invalid;
  logic [bc_pkg::MAG_BITS-1:0]    n_mag;
  logic [bc_pkg::MAG_BITS-1:0]    k_mag;
  logic [bc_pkg::MAG_BITS-1:0]    n_minus_k;
  logic [bc_pkg::MAG_BITS-1:0]    k_red;
  logic [bc_pkg::MAG_BITS-1:0]    mult;
  logic [bc_pkg::MAG_BITS-1:0]    divisor;
  logic [bc_pkg::PROD_BITS-1:0]   prod;
  logic [bc_pkg::MAG_BITS-1:0]    rem_sh;
  logic                           rem_ge;
  logic [bc_pkg::MAG_BITS-1:0]    rem_diff;

  // argument check and symmetry reduction
  always_comb begin
    n_mag     = n_value[bc_pkg::MAG_BITS-1:0];
    k_mag     = k_value[bc_pkg::MAG_BITS-1:0];
    invalid   = n_value[bc_pkg::ARG_BITS-1] | k_value[bc_pkg::ARG_BITS-1] | (k_mag > n_mag);
    n_minus_k = n_mag - k_mag;
    k_red     = (k_mag > n_minus_k) ? n_minus_k : k_mag;
  end

  assign mult    = n_reg - {1'b0, idx};
  assign divisor = {1'b0, idx} + bc_pkg::MAG_BITS'(1);
  assign prod    = bc_pkg::PROD_BITS'(acc) * bc_pkg::PROD_BITS'(mult);

  // one quotient bit per cycle, dividend shifted out of acc
  assign rem_sh   = {rem, acc[bc_pkg::RESULT_BITS-1]};
  assign rem_ge   = (rem_sh >= divisor);
  assign rem_diff = rem_sh - divisor;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_reg    <= n_mag;
      idx      <= '0;
      overflow <= 1'b0;
      if (invalid) begin
        rounds <= '0;
        acc    <= '0;
      end else begin
        rounds <= k_red[bc_pkg::ROUND_BITS-1:0];
        acc    <= bc_pkg::RESULT_BITS'(1);
      end
    end else if (cmd.mul) begin
      acc      <= prod[bc_pkg::RESULT_BITS-1:0];
      overflow <= overflow | (prod[bc_pkg::PROD_BITS-1:bc_pkg::RESULT_BITS] != '0);
      rem      <= '0;
      bitcnt   <= '0;
    end else if (cmd.div_step) begin
      acc    <= {acc[bc_pkg::RESULT_BITS-2:0], rem_ge};
      rem    <= rem_ge ? rem_diff[bc_pkg::ROUND_BITS-1:0] : rem_sh[bc_pkg::ROUND_BITS-1:0];
      bitcnt <= bitcnt + bc_pkg::BITCNT_BITS'(1);
      if (status.div_last) begin
        idx <= idx + bc_pkg::ROUND_BITS'(1);
      end
    end
  end

  assign status.rounds_done = (idx == rounds);
  assign status.div_last    = (bitcnt == bc_pkg::BITCNT_BITS'(bc_pkg::RESULT_BITS - 1));

endmodule

// ===== rtl/core/binomial_coefficient.sv =====
// binomial coefficient unit top level
// Computes C(n,k) for signed 8-bit n and k, one transaction at a time. Negative
// arguments or k > n give zero. Otherwise k is reduced to min(k, n-k) and each of
// the k rounds multiplies the accumulator by (n-i) and then divides it by (i+1)
// in a bit-serial restoring divider, one quotient bit per cycle.
// There are k' = min(k, n-k) rounds, at most 63, and the bit-serial divider
// dominates the time each item takes. The result stays on the master side until
// taken, and the next input transaction is accepted after that. overflow is set
// if any product needed more than 64 bits.
module binomial_coefficient (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bc_pkg::IN_BITS-1:0]    s_tdata,  // n_value [7:0], k_value [15:8]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bc_pkg::OUT_BITS-1:0]   m_tdata   // coefficient [63:0], overflow [64], zeros above
);

  bc_pkg::bc_cmd_t                 cmd;
  bc_pkg::bc_status_t              status;
  logic [bc_pkg::RESULT_BITS-1:0]  acc;
  logic                            overflow;
  logic [bc_pkg::COEF_BITS-1:0]    coefficient;

  bc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bc_datapath u_datapath (
    .clk      (clk),
    .n_value  (s_tdata[bc_pkg::ARG_BITS-1:0]),
    .k_value  (s_tdata[bc_pkg::IN_BITS-1:bc_pkg::ARG_BITS]),
    .cmd      (cmd),
    .status   (status),
    .acc      (acc),
    .overflow (overflow)
  );

  assign coefficient = bc_pkg::COEF_BITS'(acc);
  assign m_tdata     = bc_pkg::OUT_BITS'({overflow, coefficient});

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the binomial coefficient unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 266;
  localparam int HOLD_CYCLES  = 3000;
  // one result per transaction, so a bit more than the slowest item is enough
  localparam int DRAIN_CYCLES = 4200;
  localparam int CYCLE_LIMIT  = 6000000;
  localparam int N_DIRECTED   = 24;

  typedef logic [bc_pkg::RESULT_BITS-1:0]   acc_t;
  typedef logic [2*bc_pkg::RESULT_BITS-1:0] wide_t;

  typedef struct {
    logic signed [bc_pkg::ARG_BITS-1:0] n_arg;
    logic signed [bc_pkg::ARG_BITS-1:0] k_arg;
    logic [bc_pkg::COEF_BITS-1:0]       coefficient;
    logic                               overflow;
  } coef_result_t;

  class coefficient_ledger;
    coef_result_t pending_q[$];
    int errors          = 0;
    int results_checked = 0;
    int invalid_count   = 0;
    int overflow_count  = 0;
    int deepest         = 0;

    task report(input string field, input coef_result_t item,
                input logic [bc_pkg::COEF_BITS-1:0] got,
                input logic [bc_pkg::COEF_BITS-1:0] want);
      errors++;
      $display("mismatch in %s for n=%0d k=%0d: got %0h, expected %0h",
               field, item.n_arg, item.k_arg, got, want);
    endtask

    // works out C(n,k) for an accepted transaction and queues it
    function void note_operands(input logic [bc_pkg::IN_BITS-1:0] data);
      int n_val, k_val, rounds, i;
      acc_t acc;
      wide_t product;
      coef_result_t item;
      item.n_arg = data[bc_pkg::ARG_BITS-1:0];
      item.k_arg = data[bc_pkg::IN_BITS-1:bc_pkg::ARG_BITS];
      n_val = item.n_arg;
      k_val = item.k_arg;
      acc = 1;
      item.overflow = 1'b0;
      rounds = 0;
      if (k_val < 0 || n_val < 0 || k_val > n_val) begin
        acc = '0;
        invalid_count++;
      end else begin
        rounds = (k_val > n_val - k_val) ? n_val - k_val : k_val;
        for (i = 0; i < rounds; i++) begin
          product = wide_t'(acc) * wide_t'(n_val - i);
          if (product[2*bc_pkg::RESULT_BITS-1:bc_pkg::RESULT_BITS] != '0)
            item.overflow = 1'b1;
          // wrapped product, then truncating division
          acc = acc_t'(product) / acc_t'(i + 1);
        end
      end
      item.coefficient = bc_pkg::COEF_BITS'(acc);
      if (item.overflow) overflow_count++;
      if (rounds > deepest) deepest = rounds;
      pending_q.push_back(item);
    endfunction

    task check_result(input logic [bc_pkg::OUT_BITS-1:0] data);
      coef_result_t want;
      results_checked++;
      if (pending_q.size() == 0) begin
        want = '{default: '0};
        report("unexpected result", want, data[bc_pkg::COEF_BITS-1:0], '0);
        return;
      end
      want = pending_q.pop_front();
      if (data[bc_pkg::COEF_BITS-1:0] !== want.coefficient)
        report("coefficient", want, data[bc_pkg::COEF_BITS-1:0], want.coefficient);
      if (data[bc_pkg::COEF_BITS] !== want.overflow)
        report("overflow", want, bc_pkg::COEF_BITS'(data[bc_pkg::COEF_BITS]),
               bc_pkg::COEF_BITS'(want.overflow));
      if (data[bc_pkg::OUT_BITS-1:bc_pkg::COEF_BITS+1] !== '0)
        report("padding", want,
               bc_pkg::COEF_BITS'(data[bc_pkg::OUT_BITS-1:bc_pkg::COEF_BITS+1]), '0);
    endtask
  endclass

  logic                        clk      = 1'b0;
  logic                        rst      = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [bc_pkg::IN_BITS-1:0]  s_tdata  = '0;  // n_value [7:0], k_value [15:8]
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [bc_pkg::OUT_BITS-1:0] m_tdata;        // coefficient [63:0], overflow [64], zeros above

  coefficient_ledger ledger = new();
  int unsigned cycle_count        = 0;
  int unsigned input_stall_cycles = 0;

  int directed_n [N_DIRECTED] = '{0, 1, 1, 2, 127, 127, 127, 127, 127, 127, -128, -128,
                                  -1, 5, 5, 0, 127, -128, 10, 60, 66, 68, 100, 85};
  int directed_k [N_DIRECTED] = '{0, 0, 1, 1, 0, 127, 1, 126, 63, 64, -128, 0,
                                  -1, -1, 6, 1, -128, 127, 5, 30, 33, 34, 50, -86};

  binomial_coefficient uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) ledger.note_operands(s_tdata);
    if (!rst && s_tvalid && !s_tready) input_stall_cycles++;
    if (!rst && m_tvalid && m_tready) ledger.check_result(m_tdata);
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 24);
    return $urandom_range(40, 150);
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 40;
    endcase
  endfunction

  task automatic offer_operands(input logic [bc_pkg::ARG_BITS-1:0] n_byte,
                                input logic [bc_pkg::ARG_BITS-1:0] k_byte);
    s_tdata  <= {k_byte, n_byte};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic sender_pause(input int pct);
    int unsigned gap;
    gap = ($urandom_range(1, 100) <= pct) ? gap_length() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // most pairs are valid with few rounds; some are deep, some raw bytes
  task automatic pick_operands(output logic [bc_pkg::ARG_BITS-1:0] n_byte,
                               output logic [bc_pkg::ARG_BITS-1:0] k_byte);
    int unsigned roll, n_val, depth;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      n_byte = bc_pkg::ARG_BITS'($urandom);
      k_byte = bc_pkg::ARG_BITS'($urandom);
    end else if (roll < 30) begin
      n_val  = $urandom_range(0, 126);
      n_byte = bc_pkg::ARG_BITS'(n_val);
      k_byte = bc_pkg::ARG_BITS'(n_val + 1);
    end else begin
      n_val = $urandom_range(0, 127);
      depth = (roll < 36 || n_val / 2 < 8) ? n_val / 2 : 8;
      depth = $urandom_range(0, depth);
      n_byte = bc_pkg::ARG_BITS'(n_val);
      k_byte = $urandom_range(0, 1) ? bc_pkg::ARG_BITS'(depth)
                                    : bc_pkg::ARG_BITS'(n_val - depth);
    end
  endtask

  initial begin : receiver
    int unsigned stall_left, window;
    int idle_pct;
    bit held;
    stall_left = 0;
    window     = 0;
    idle_pct   = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (window == 0) begin
        idle_pct = pick_idle_pct();
        window   = 300;
      end
      window--;
      if (!held && ledger.results_checked >= 40) begin
        // long hold-off: the block fills up and stalls its input
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(1, 100) <= idle_pct) stall_left = gap_length();
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [bc_pkg::ARG_BITS-1:0] n_byte, k_byte;
    int idle_pct;
    int i;
    idle_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < N_DIRECTED; i++) begin
      offer_operands(bc_pkg::ARG_BITS'(directed_n[i]), bc_pkg::ARG_BITS'(directed_k[i]));
      sender_pause(i < N_DIRECTED / 2 ? 0 : 30);
    end

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) idle_pct = pick_idle_pct();
      pick_operands(n_byte, k_byte);
      offer_operands(n_byte, k_byte);
      // the last transaction always drops tvalid afterwards
      sender_pause(i == RANDOM_ITEMS - 1 ? 100 : idle_pct);
    end

    while (ledger.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d operand pairs checked: %0d invalid, %0d with overflow, up to %0d rounds",
             ledger.results_checked, ledger.invalid_count, ledger.overflow_count,
             ledger.deepest);
    $display("output held off for %0d cycles once; input stalled %0d cycles in all",
             HOLD_CYCLES, input_stall_cycles);
    if (ledger.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== binomial_coefficient.f =====
rtl/core/bc_pkg.sv
rtl/core/bc_ctrl.sv
rtl/core/bc_datapath.sv
rtl/core/binomial_coefficient.sv
tb/testbench.sv
